[sv/vmrb_pkg.sv]
// ----------------------------------------------------------------------------
// vmrb_pkg: shared types and constants of the message ring buffer
// Item and result layouts, function and status codes, default sizes.
// ----------------------------------------------------------------------------
package vmrb_pkg;

  // Default configuration of the block
  localparam int RING_DEPTH_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 4;

  // Ring size limits and reset value of the size register
  localparam int MIN_SIZE   = 16;
  localparam int SIZE_RESET = 1024;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 10;
  localparam int BYTE_W   = 8;
  localparam int SIZE_W   = 11;
  localparam int FREE_W   = 10;
  localparam int COUNT_W  = 9;
  localparam int FREE_MAX = 1023;

  // Item function codes (code 3 has no meaning)
  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_PUSH  = 2'd1,
    FUNC_POP   = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ORDER   = 2'd3
  } status_e;

  // One input item
  typedef struct packed {
    func_e             func;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data;
  } item_t;

  // Per-item result fields held in the output register
  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] read_byte;
    logic [LEN_W-1:0]  message_length;
    logic              last;
  } result_t;

endpackage

[sv/variable_message_ring_buffer_core.sv]
// ----------------------------------------------------------------------------
// variable_message_ring_buffer_core: length-prefixed message ring buffer
// Byte ring of variable-length messages with header, push and pop items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transaction:
//   func_i selects start a send (length_i), push a payload byte (data_i) or
//   pop the next byte. Output channel (out_valid_o / out_stall_i) returns one
//   result per item: status, popped byte, message length, last mark, free
//   payload bytes and the number of stored messages.
//   The configuration channel (cfg_valid_i / cfg_ready_o, cfg_data_i) sets
//   the ring size and empties the ring; write it only while the block is idle.
//   An accepted item passes the input register and then the result register;
//   one item is taken every cycle while the receiver does not stall. Both the
//   byte store and the message length queue read ahead of the item that needs
//   them, so each item is one pass of logic from input to result register.
//   While the receiver stalls, the result register holds and the input
//   register fills; a further input then stalls until the result is taken.
//   Reset empties the ring and sets the size to 1024 bytes (clamped to the
//   store depth); store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module variable_message_ring_buffer_core #(
  parameter int RING_DEPTH   = vmrb_pkg::RING_DEPTH_DEF,
  parameter int HEADER_BYTES = vmrb_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vmrb_pkg::FUNC_W-1:0]   func_i,
  input  logic [vmrb_pkg::LEN_W-1:0]    length_i,
  input  logic [vmrb_pkg::BYTE_W-1:0]   data_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [vmrb_pkg::BYTE_W-1:0]   read_byte_o,
  output logic [vmrb_pkg::LEN_W-1:0]    message_length_o,
  output logic                          last_o,
  output logic [vmrb_pkg::FREE_W-1:0]   free_bytes_o,
  output logic [vmrb_pkg::COUNT_W-1:0]  message_count_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vmrb_pkg::SIZE_W-1:0]   cfg_data_i
);

  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int LQ_DEPTH = RING_DEPTH / HEADER_BYTES;
  localparam int LQ_W     = $clog2(LQ_DEPTH);

  vmrb_pkg::item_t             item_q;
  logic                        item_valid_q, item_valid_d;
  vmrb_pkg::result_t           res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;
  logic                        proc;
  logic                        in_take;

  logic                        ring_we;
  logic [PTR_W-1:0]            ring_waddr;
  logic [vmrb_pkg::BYTE_W-1:0] ring_wdata;
  logic [PTR_W-1:0]            ring_raddr;
  logic [vmrb_pkg::BYTE_W-1:0] ring_rdata;
  logic                        lq_we;
  logic [LQ_W-1:0]             lq_waddr;
  logic [vmrb_pkg::LEN_W-1:0]  lq_wdata;
  logic [LQ_W-1:0]             lq_raddr;
  logic [vmrb_pkg::LEN_W-1:0]  lq_rdata;

  // Handshake: process when the result register can take a new result
  assign out_free     = !out_valid_q || !out_stall_i;
  assign proc         = item_valid_q && out_free;
  assign in_stall_o   = item_valid_q && !out_free;
  assign in_take      = in_valid_i && !in_stall_o;
  assign item_valid_d = in_take || (item_valid_q && !proc);
  assign out_valid_d  = proc || (out_valid_q && out_stall_i);
  assign cfg_ready_o  = 1'b1;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func   <= vmrb_pkg::func_e'(func_i);
      item_q.length <= length_i;
      item_q.data   <= data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  vmrb_ctrl #(
    .RING_DEPTH   (RING_DEPTH),
    .HEADER_BYTES (HEADER_BYTES),
    .PTR_W        (PTR_W),
    .LQ_DEPTH     (LQ_DEPTH),
    .LQ_W         (LQ_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .proc_i          (proc),
    .item_i          (item_q),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .ring_we_o       (ring_we),
    .ring_waddr_o    (ring_waddr),
    .ring_wdata_o    (ring_wdata),
    .ring_raddr_o    (ring_raddr),
    .ring_rdata_i    (ring_rdata),
    .lq_we_o         (lq_we),
    .lq_waddr_o      (lq_waddr),
    .lq_wdata_o      (lq_wdata),
    .lq_raddr_o      (lq_raddr),
    .lq_rdata_i      (lq_rdata),
    .res_o           (res_d),
    .free_bytes_o    (free_bytes_o),
    .message_count_o (message_count_o)
  );

  // Payload byte store
  vmrb_store #(
    .DATA_W (vmrb_pkg::BYTE_W),
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Message length queue, one entry per header in the ring
  vmrb_store #(
    .DATA_W (vmrb_pkg::LEN_W),
    .DEPTH  (LQ_DEPTH),
    .ADDR_W (LQ_W)
  ) u_lenq (
    .clk_i   (clk_i),
    .we_i    (lq_we),
    .waddr_i (lq_waddr),
    .wdata_i (lq_wdata),
    .raddr_i (lq_raddr),
    .rdata_o (lq_rdata)
  );

  // Drive result ports
  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign read_byte_o      = res_q.read_byte;
  assign message_length_o = res_q.message_length;
  assign last_o           = res_q.last;

endmodule

[sv/vmrb_store.sv]
// ----------------------------------------------------------------------------
// vmrb_store: simple dual-port store with registered read
// One write and one read per cycle; a read of the address being written
// returns the new data.
// ----------------------------------------------------------------------------
module vmrb_store #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, forward the data written in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/vmrb_ctrl.sv]
// ----------------------------------------------------------------------------
// vmrb_ctrl: pointer state and per-item decision logic
// Checks room, advances the write, commit and read pointers, keeps the
// open send and receive, and picks the read addresses for the next item.
// ----------------------------------------------------------------------------
module vmrb_ctrl #(
  parameter int RING_DEPTH   = vmrb_pkg::RING_DEPTH_DEF,
  parameter int HEADER_BYTES = vmrb_pkg::HEADER_BYTES_DEF,
  parameter int PTR_W        = $clog2(RING_DEPTH),
  parameter int LQ_DEPTH     = RING_DEPTH / HEADER_BYTES,
  parameter int LQ_W         = $clog2(LQ_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item to process this cycle
  input  logic                          proc_i,
  input  vmrb_pkg::item_t               item_i,
  // configuration write
  input  logic                          cfg_we_i,
  input  logic [vmrb_pkg::SIZE_W-1:0]   cfg_data_i,
  // byte store
  output logic                          ring_we_o,
  output logic [PTR_W-1:0]              ring_waddr_o,
  output logic [vmrb_pkg::BYTE_W-1:0]   ring_wdata_o,
  output logic [PTR_W-1:0]              ring_raddr_o,
  input  logic [vmrb_pkg::BYTE_W-1:0]   ring_rdata_i,
  // message length queue
  output logic                          lq_we_o,
  output logic [LQ_W-1:0]               lq_waddr_o,
  output logic [vmrb_pkg::LEN_W-1:0]    lq_wdata_o,
  output logic [LQ_W-1:0]               lq_raddr_o,
  input  logic [vmrb_pkg::LEN_W-1:0]    lq_rdata_i,
  // results
  output vmrb_pkg::result_t             res_o,
  output logic [vmrb_pkg::FREE_W-1:0]   free_bytes_o,
  output logic [vmrb_pkg::COUNT_W-1:0]  message_count_o
);

  localparam int SW = $clog2(RING_DEPTH + 1);
  localparam int AW = SW + 1;
  localparam int CW = (SW > vmrb_pkg::SIZE_W) ? SW : vmrb_pkg::SIZE_W;
  localparam int FW = ((AW > vmrb_pkg::LEN_W) ? AW : vmrb_pkg::LEN_W) + 1;
  localparam int RESET_SIZE = (vmrb_pkg::SIZE_RESET > RING_DEPTH) ? RING_DEPTH
                                                                   : vmrb_pkg::SIZE_RESET;
  localparam logic [AW-1:0] HDR_INC = AW'(HEADER_BYTES);
  localparam bit HDR_WIDE = (HEADER_BYTES >= 2);

  logic [SW-1:0]                    size_q, size_d;
  logic [PTR_W-1:0]                 wp_q, wp_d;
  logic [PTR_W-1:0]                 cp_q, cp_d;
  logic [PTR_W-1:0]                 rp_q, rp_d;
  logic [vmrb_pkg::COUNT_W-1:0]     stored_q, stored_d;
  logic [vmrb_pkg::LEN_W-1:0]       send_rem_q, send_rem_d;
  logic [vmrb_pkg::LEN_W-1:0]       recv_rem_q, recv_rem_d;
  logic [vmrb_pkg::LEN_W-1:0]       recv_len_q, recv_len_d;
  logic                             send_open_q, send_open_d;
  logic                             recv_open_q, recv_open_d;
  logic [LQ_W-1:0]                  lq_wr_q, lq_wr_d;
  logic [LQ_W-1:0]                  lq_rd_q, lq_rd_d;

  logic [AW-1:0]                    used;
  logic [AW-1:0]                    free_raw;
  logic                             fits;
  logic [FW-1:0]                    free_ext;
  logic [CW-1:0]                    cfg_ext;
  logic [SW-1:0]                    cfg_size;
  logic                             pop_go;
  logic [vmrb_pkg::LEN_W-1:0]       rem_now;
  logic [vmrb_pkg::LEN_W-1:0]       len_now;
  logic [PTR_W-1:0]                 rp_now;

  // Add a small step to a ring pointer, wrapping at the ring size
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [AW-1:0]    inc,
                                                input logic [SW-1:0]    s);
    logic [AW-1:0] n;
    n = AW'(p) + inc;
    if (n >= AW'(s)) begin
      n = n - AW'(s);
    end
    return n[PTR_W-1:0];
  endfunction

  // Step a length queue pointer
  function automatic logic [LQ_W-1:0] lq_inc(input logic [LQ_W-1:0] p);
    return (p == LQ_W'(LQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Occupied and free ring bytes
  always_comb begin
    if (wp_q >= rp_q) begin
      used = AW'(wp_q) - AW'(rp_q);
    end else begin
      used = AW'(wp_q) + AW'(size_q) - AW'(rp_q);
    end
    if ((used + 1'b1) >= AW'(size_q)) begin
      free_raw = '0;
    end else begin
      free_raw = AW'(size_q) - 1'b1 - used;
    end
  end

  assign fits = ((FW'(HEADER_BYTES) + FW'(item_i.length)) <= FW'(free_raw)) &&
                (HDR_WIDE || (item_i.length[vmrb_pkg::LEN_W-1:8] == '0));

  // Free payload room after a header, floor zero, saturated
  always_comb begin
    if (free_raw > HDR_INC) begin
      free_ext = FW'(free_raw - HDR_INC);
    end else begin
      free_ext = '0;
    end
    if (free_ext > FW'(vmrb_pkg::FREE_MAX)) begin
      free_bytes_o = vmrb_pkg::FREE_W'(vmrb_pkg::FREE_MAX);
    end else begin
      free_bytes_o = free_ext[vmrb_pkg::FREE_W-1:0];
    end
  end

  assign message_count_o = stored_q;

  // Clamp the configured size into the supported range
  always_comb begin
    cfg_ext = CW'(cfg_data_i);
    if (cfg_ext < CW'(vmrb_pkg::MIN_SIZE)) begin
      cfg_size = SW'(vmrb_pkg::MIN_SIZE);
    end else if (cfg_ext > CW'(RING_DEPTH)) begin
      cfg_size = SW'(RING_DEPTH);
    end else begin
      cfg_size = cfg_ext[SW-1:0];
    end
  end

  // Next state and result of the current item
  always_comb begin
    size_d       = size_q;
    wp_d         = wp_q;
    cp_d         = cp_q;
    rp_d         = rp_q;
    stored_d     = stored_q;
    send_rem_d   = send_rem_q;
    recv_rem_d   = recv_rem_q;
    recv_len_d   = recv_len_q;
    send_open_d  = send_open_q;
    recv_open_d  = recv_open_q;
    lq_wr_d      = lq_wr_q;
    lq_rd_d      = lq_rd_q;
    ring_we_o    = 1'b0;
    ring_waddr_o = wp_q;
    ring_wdata_o = item_i.data;
    lq_we_o      = 1'b0;
    lq_waddr_o   = lq_wr_q;
    lq_wdata_o   = item_i.length;
    res_o        = '0;
    res_o.status = vmrb_pkg::ST_OK;
    pop_go       = 1'b0;
    rem_now      = recv_rem_q;
    len_now      = recv_len_q;
    rp_now       = rp_q;

    if (cfg_we_i) begin
      // Resize empties the ring
      size_d      = cfg_size;
      wp_d        = '0;
      cp_d        = '0;
      rp_d        = '0;
      stored_d    = '0;
      send_rem_d  = '0;
      recv_rem_d  = '0;
      recv_len_d  = '0;
      send_open_d = 1'b0;
      recv_open_d = 1'b0;
      lq_wr_d     = '0;
      lq_rd_d     = '0;
    end else if (proc_i) begin
      case (item_i.func)
        vmrb_pkg::FUNC_START: begin
          if (send_open_q) begin
            res_o.status = vmrb_pkg::ST_ORDER;
          end else if (!fits) begin
            res_o.status = vmrb_pkg::ST_NO_ROOM;
          end else begin
            // Reserve the header, queue the length
            wp_d        = wrap_add(wp_q, HDR_INC, size_q);
            lq_we_o     = 1'b1;
            lq_wr_d     = lq_inc(lq_wr_q);
            send_open_d = 1'b1;
            send_rem_d  = item_i.length;
            if (item_i.length == '0) begin
              cp_d        = wrap_add(wp_q, HDR_INC, size_q);
              stored_d    = stored_q + 1'b1;
              send_open_d = 1'b0;
            end
          end
        end
        vmrb_pkg::FUNC_PUSH: begin
          if (!send_open_q || (send_rem_q == '0)) begin
            res_o.status = vmrb_pkg::ST_ORDER;
          end else begin
            ring_we_o  = 1'b1;
            wp_d       = wrap_add(wp_q, AW'(1), size_q);
            send_rem_d = send_rem_q - 1'b1;
            if (send_rem_q == vmrb_pkg::LEN_W'(1)) begin
              cp_d        = wrap_add(wp_q, AW'(1), size_q);
              stored_d    = stored_q + 1'b1;
              send_open_d = 1'b0;
            end
          end
        end
        vmrb_pkg::FUNC_POP: begin
          if (recv_open_q) begin
            pop_go = 1'b1;
          end else if ((stored_q == '0) || (rp_q == cp_q)) begin
            res_o.status = vmrb_pkg::ST_EMPTY;
          end else begin
            // Open the oldest message: skip its header, take its length
            pop_go      = 1'b1;
            len_now     = lq_rdata_i;
            rem_now     = lq_rdata_i;
            rp_now      = wrap_add(rp_q, HDR_INC, size_q);
            lq_rd_d     = lq_inc(lq_rd_q);
            recv_len_d  = lq_rdata_i;
            recv_open_d = 1'b1;
          end
          if (pop_go) begin
            res_o.message_length = len_now;
            if (rem_now == '0) begin
              res_o.last  = 1'b1;
              rp_d        = rp_now;
              recv_rem_d  = rem_now;
              recv_open_d = 1'b0;
              if (stored_q != '0) begin
                stored_d = stored_q - 1'b1;
              end
            end else begin
              res_o.read_byte = ring_rdata_i;
              rp_d            = wrap_add(rp_now, AW'(1), size_q);
              recv_rem_d      = rem_now - 1'b1;
              if (rem_now == vmrb_pkg::LEN_W'(1)) begin
                res_o.last  = 1'b1;
                recv_open_d = 1'b0;
                if (stored_q != '0) begin
                  stored_d = stored_q - 1'b1;
                end
              end
            end
          end
        end
        default: begin
          res_o.status = vmrb_pkg::ST_ORDER;
        end
      endcase
    end
  end

  // Prefetch the next payload byte and the oldest queued length
  assign ring_raddr_o = recv_open_d ? rp_d : wrap_add(rp_d, HDR_INC, size_d);
  assign lq_raddr_o   = lq_rd_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SW'(RESET_SIZE);
      wp_q        <= '0;
      cp_q        <= '0;
      rp_q        <= '0;
      stored_q    <= '0;
      send_rem_q  <= '0;
      recv_rem_q  <= '0;
      recv_len_q  <= '0;
      send_open_q <= 1'b0;
      recv_open_q <= 1'b0;
      lq_wr_q     <= '0;
      lq_rd_q     <= '0;
    end else begin
      size_q      <= size_d;
      wp_q        <= wp_d;
      cp_q        <= cp_d;
      rp_q        <= rp_d;
      stored_q    <= stored_d;
      send_rem_q  <= send_rem_d;
      recv_rem_q  <= recv_rem_d;
      recv_len_q  <= recv_len_d;
      send_open_q <= send_open_d;
      recv_open_q <= recv_open_d;
      lq_wr_q     <= lq_wr_d;
      lq_rd_q     <= lq_rd_d;
    end
  end

  // Pointers stay inside the configured ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW'(wp_q) < AW'(size_q)) && (AW'(rp_q) < AW'(size_q)) && (AW'(cp_q) < AW'(size_q)))
    else $error("ring pointer beyond ring size");

  // An open send always has payload still owed
  a_send_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_open_q |-> (send_rem_q != '0))
    else $error("open send with no bytes remaining");

  // With no send open every written byte is committed
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !send_open_q |-> (wp_q == cp_q))
    else $error("uncommitted bytes with no send open");

endmodule
